[hdl/hoe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hoe_pkg;

    localparam logic [31:0] MAGIC_HEADER = 32'd1011;
    localparam logic [31:0] TYPE_CODE    = 32'd1001;
    localparam logic [31:0] TYPE_DATA    = 32'd1002;
    localparam logic [31:0] TYPE_BSS     = 32'd1003;
    localparam logic [31:0] TYPE_SYMBOL  = 32'd1008;
    localparam logic [31:0] TYPE_DEBUG   = 32'd1009;
    localparam logic [31:0] TYPE_END     = 32'd1010;

    localparam logic [7:0] LIMIT_RESET = 8'd16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd3;

    localparam logic [0:0] KIND_CODE = 1'b0;
    localparam logic [0:0] KIND_DATA = 1'b1;

    typedef struct packed {
        logic [31:0] rom_word;
        logic        source_kind;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

[hdl/hoe_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module hoe_step
    import hoe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [31:0] word_in,
    input  wire logic [7:0]  hunk_limit,
    output logic             res_valid,
    output result_t          res
);

    typedef enum logic [4:0] {
        PH_MAGIC,
        PH_STRINGS,
        PH_TABLE,
        PH_FIRST,
        PH_LAST,
        PH_SIZES,
        PH_TYPE,
        PH_BODY_LEN,
        PH_BODY,
        PH_SYM_LEN,
        PH_SYM_SKIP,
        PH_SKIP,
        PH_BSS_LEN,
        PH_ERR_MAGIC,
        PH_ERR_COUNT,
        PH_ERR_TYPE,
        PH_DBG_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] words_left_reg, words_left_next;
    logic [31:0] first_reg, first_next;
    logic        kind_reg, kind_next;

    logic [31:0] span;
    logic [31:0] left_dec;
    logic        left_last;
    logic        too_many;

    assign span      = word_in - first_reg;
    assign left_dec  = words_left_reg - 32'd1;
    assign left_last = (words_left_reg == 32'd1);
    // count = span + 1 exceeds the limit exactly when span >= limit
    assign too_many  = (word_in < first_reg) || (span >= {24'd0, hunk_limit});

    always_comb begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        first_next      = first_reg;
        kind_next       = kind_reg;
        res_valid       = 1'b0;
        res.rom_word    = 32'd0;
        res.source_kind = KIND_CODE;
        res.status      = ST_OK;

        case (phase_reg)
            PH_MAGIC: begin
                if (word_in != MAGIC_HEADER) begin
                    phase_next = PH_ERR_MAGIC;
                    res_valid  = 1'b1;
                    res.status = ST_BAD_MAGIC;
                end else begin
                    phase_next = PH_STRINGS;
                end
            end
            PH_STRINGS: phase_next = PH_TABLE;
            PH_TABLE:   phase_next = PH_FIRST;
            PH_FIRST: begin
                first_next = word_in;
                phase_next = PH_LAST;
            end
            PH_LAST: begin
                if (too_many) begin
                    phase_next = PH_ERR_COUNT;
                    res_valid  = 1'b1;
                    res.status = ST_TOO_MANY;
                end else begin
                    words_left_next = span + 32'd1;
                    phase_next      = PH_SIZES;
                end
            end
            PH_SIZES: begin
                words_left_next = left_dec;
                if (left_last) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                case (word_in)
                    TYPE_CODE: begin
                        kind_next  = KIND_CODE;
                        phase_next = PH_BODY_LEN;
                    end
                    TYPE_DATA: begin
                        kind_next  = KIND_DATA;
                        phase_next = PH_BODY_LEN;
                    end
                    TYPE_SYMBOL: phase_next = PH_SYM_LEN;
                    TYPE_DEBUG: begin
                        kind_next       = KIND_CODE;
                        words_left_next = 32'd0;
                        phase_next      = PH_SKIP;
                    end
                    TYPE_BSS: phase_next = PH_BSS_LEN;
                    TYPE_END: phase_next = PH_TYPE;
                    default: begin
                        phase_next = PH_ERR_TYPE;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_TYPE;
                    end
                endcase
            end
            PH_BODY_LEN: begin
                words_left_next = word_in;
                phase_next      = (word_in == 32'd0) ? PH_TYPE : PH_BODY;
            end
            PH_BODY: begin
                res_valid       = 1'b1;
                res.rom_word    = word_in;
                res.source_kind = kind_reg;
                words_left_next = left_dec;
                if (left_last) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_SYM_LEN: begin
                if (word_in == 32'd0) begin
                    phase_next = PH_TYPE;
                end else begin
                    words_left_next = word_in;
                    phase_next      = PH_SYM_SKIP;
                end
            end
            PH_SYM_SKIP: begin
                // name words count down, then the value word closes the entry
                if (words_left_reg == 32'd0) begin
                    phase_next = PH_SYM_LEN;
                end else begin
                    words_left_next = left_dec;
                end
            end
            PH_SKIP: begin
                // debug length word; entered with the count already cleared
                if (words_left_reg == 32'd0) begin
                    words_left_next = word_in;
                    phase_next      = (word_in == 32'd0) ? PH_TYPE : PH_DBG_BODY;
                end
            end
            PH_DBG_BODY: begin
                words_left_next = left_dec;
                if (left_last) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_BSS_LEN: phase_next = PH_TYPE;
            PH_ERR_MAGIC: begin
                res_valid  = 1'b1;
                res.status = ST_BAD_MAGIC;
            end
            PH_ERR_COUNT: begin
                res_valid  = 1'b1;
                res.status = ST_TOO_MANY;
            end
            PH_ERR_TYPE: begin
                res_valid  = 1'b1;
                res.status = ST_BAD_TYPE;
            end
            default: phase_next = PH_TYPE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MAGIC;
            words_left_reg <= 32'd0;
            first_reg      <= 32'd0;
            kind_reg       <= KIND_CODE;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            first_reg      <= first_next;
            kind_reg       <= kind_next;
        end
    end

endmodule

`default_nettype wire

[hdl/hoe_outbuf.sv]
`timescale 1ns / 1ps
`default_nettype none

module hoe_outbuf
    import hoe_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // upstream is held off while the skid entry is full
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

[hdl/hunk_object_to_rom_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Moves
// -------   -------------------------------------   ---------------------------------
// input     s_valid s_ready s_in_word               one file word per transaction
// result    m_valid m_ready m_rom_word              ROM word or error, 0 or 1
//           m_source_kind m_status                  per input word
// config    psel penable pwrite paddr pwdata        hunk_limit at byte address 0
//           prdata pready
//
// One word per cycle sustained while the result side has room; a result reaches
// m_valid through the input register, then the result register (or skid entry).
// Reset (synchronous, aresetn low) restores hunk_limit to 16 and the parser to
// the header-magic phase with the error cleared.
// A stalled result goes to a skid entry; s_ready drops only while it is full.

module hunk_object_to_rom_extractor
    import hoe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_in_word,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_rom_word,
    output logic             m_source_kind,
    output logic [1:0]       m_status,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] ADDR_HUNK_LIMIT = 2'd0;

    logic [7:0]  limit_reg;
    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        room;
    logic        step_en;
    logic        res_valid;
    result_t     res;
    result_t     out_data;

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_HUNK_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_HUNK_LIMIT)) begin
            limit_reg <= pwdata[7:0];
        end
    end

    // advance the held word whenever the result side has room
    assign step_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_in_word;
        end
    end

    hoe_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .word_in    (in_word_reg),
        .hunk_limit (limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    hoe_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step_en && res_valid),
        .push_data (res),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_rom_word    = out_data.rom_word;
    assign m_source_kind = out_data.source_kind;
    assign m_status      = out_data.status;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hoe_pkg::*;

    localparam logic [1:0] REG_HUNK_LIMIT = 2'd0;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 360;
    localparam int TAIL_WORDS    = 45;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [3:0] {
        PS_MAGIC, PS_STRINGS, PS_TABLE, PS_FIRST, PS_LAST, PS_SIZES, PS_TYPE,
        PS_BODY_LEN, PS_BODY, PS_SYM_LEN, PS_SYM_SKIP, PS_DBG_LEN, PS_DBG_SKIP,
        PS_BSS_LEN
    } parse_phase_e;

    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_RESULT} exp_mode_e;

    typedef struct packed {
        logic [31:0] word;
        exp_mode_e   mode;
        result_t     res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_in_word = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_rom_word;
    logic        m_source_kind;
    logic [1:0]  m_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = REG_HUNK_LIMIT;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    parse_phase_e pp_phase = PS_MAGIC;
    logic [31:0]  pp_left = 32'd0;
    logic [31:0]  pp_first = 32'd0;
    logic         pp_kind = KIND_CODE;
    logic [1:0]   pp_err = ST_OK;
    logic [7:0]   cfg_limit = LIMIT_RESET;

    result_t   rom_expect[$];
    stim_row_t directed_rows[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int words_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int n_code = 0, n_data = 0, n_sym = 0, n_dbg = 0, n_bss = 0, n_end = 0;

    hunk_object_to_rom_extractor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_word     (s_in_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rom_word    (m_rom_word),
        .m_source_kind (m_source_kind),
        .m_status      (m_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rom_expect.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    // Walk one file word through the parser and return the result it causes.
    function automatic void parse_word(input logic [31:0] w, output bit got,
                                       output result_t r);
        logic [32:0] span;
        got  = 1'b0;
        r    = '0;
        span = '0;
        if (pp_err == ST_OK) begin
            case (pp_phase)
                PS_MAGIC: begin
                    if (w != MAGIC_HEADER) pp_err = ST_BAD_MAGIC;
                    else pp_phase = PS_STRINGS;
                end
                PS_STRINGS: pp_phase = PS_TABLE;
                PS_TABLE:   pp_phase = PS_FIRST;
                PS_FIRST: begin
                    pp_first = w;
                    pp_phase = PS_LAST;
                end
                PS_LAST: begin
                    span = {1'b0, w - pp_first} + 33'd1;
                    if (w < pp_first || span > {25'd0, cfg_limit}) begin
                        pp_err = ST_TOO_MANY;
                    end else begin
                        pp_left  = span[31:0];
                        pp_phase = PS_SIZES;
                    end
                end
                PS_SIZES: begin
                    pp_left = pp_left - 32'd1;
                    if (pp_left == 32'd0) pp_phase = PS_TYPE;
                end
                PS_TYPE: begin
                    case (w)
                        TYPE_CODE, TYPE_DATA: begin
                            pp_kind  = (w == TYPE_DATA) ? KIND_DATA : KIND_CODE;
                            pp_phase = PS_BODY_LEN;
                        end
                        TYPE_SYMBOL: pp_phase = PS_SYM_LEN;
                        TYPE_DEBUG: begin
                            pp_kind  = KIND_CODE;
                            pp_left  = 32'd0;
                            pp_phase = PS_DBG_LEN;
                        end
                        TYPE_BSS: pp_phase = PS_BSS_LEN;
                        TYPE_END: pp_phase = PS_TYPE;
                        default:  pp_err = ST_BAD_TYPE;
                    endcase
                end
                PS_BODY_LEN: begin
                    pp_left  = w;
                    pp_phase = (w == 32'd0) ? PS_TYPE : PS_BODY;
                end
                PS_BODY: begin
                    got     = 1'b1;
                    r       = '{w, pp_kind, ST_OK};
                    pp_left = pp_left - 32'd1;
                    if (pp_left == 32'd0) pp_phase = PS_TYPE;
                end
                PS_SYM_LEN: begin
                    if (w == 32'd0) begin
                        pp_phase = PS_TYPE;
                    end else begin
                        pp_left  = w;
                        pp_phase = PS_SYM_SKIP;
                    end
                end
                PS_SYM_SKIP: begin
                    // name words count down, the value word ends the entry
                    if (pp_left == 32'd0) pp_phase = PS_SYM_LEN;
                    else pp_left = pp_left - 32'd1;
                end
                PS_DBG_LEN: begin
                    pp_left  = w;
                    pp_phase = (w == 32'd0) ? PS_TYPE : PS_DBG_SKIP;
                end
                PS_DBG_SKIP: begin
                    pp_left = pp_left - 32'd1;
                    if (pp_left == 32'd0) pp_phase = PS_TYPE;
                end
                PS_BSS_LEN: pp_phase = PS_TYPE;
                default:    pp_phase = PS_TYPE;
            endcase
        end
        if (pp_err != ST_OK) begin
            got = 1'b1;
            r   = '{32'd0, KIND_CODE, pp_err};
        end
    endfunction

    task automatic send_word(input logic [31:0] w, input exp_mode_e mode,
                             input result_t res);
        bit      got;
        result_t pred;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_word(w, got, pred);
        words_sent++;
        case (mode)
            EXP_PREDICT: if (got) rom_expect.push_back(pred);
            EXP_RESULT:  rom_expect.push_back(res);
            default: ;
        endcase
    endtask

    task automatic put(input logic [31:0] w);
        send_word(w, EXP_PREDICT, '0);
    endtask

    task automatic add_row(input logic [31:0] w, input exp_mode_e mode,
                           input result_t res);
        directed_rows.push_back('{w, mode, res});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rom_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HUNK_LIMIT;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_limit = value[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Payload and skipped words: mostly random, sometimes extremes or hunk codes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: begin
                case ($urandom_range(6))
                    0: return TYPE_CODE;
                    1: return TYPE_DATA;
                    2: return TYPE_BSS;
                    3: return TYPE_SYMBOL;
                    4: return TYPE_DEBUG;
                    5: return TYPE_END;
                    default: return MAGIC_HEADER;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic emit_random_hunk();
        int pick, len, entries, n;
        pick = $urandom_range(99);
        if (pick < 40) begin
            if ($urandom_range(1) == 1) begin
                put(TYPE_DATA);
                n_data++;
            end else begin
                put(TYPE_CODE);
                n_code++;
            end
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
            put(len);
            repeat (len) put(pick_word());
        end else if (pick < 55) begin
            put(TYPE_SYMBOL);
            n_sym++;
            entries = $urandom_range(3);
            repeat (entries) begin
                n = $urandom_range(3, 1);
                put(n);
                repeat (n + 1) put(pick_word());
            end
            put(32'd0);
        end else if (pick < 70) begin
            put(TYPE_DEBUG);
            n_dbg++;
            len = $urandom_range(6);
            put(len);
            repeat (len) put(pick_word());
        end else if (pick < 85) begin
            put(TYPE_BSS);
            n_bss++;
            put($urandom);
        end else begin
            put(TYPE_END);
            n_end++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rom_expect.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: word %h kind %0d status %0d",
                             m_rom_word, m_source_kind, m_status);
                mismatch_count++;
            end else begin
                want = rom_expect.pop_front();
                results_checked++;
                if (m_rom_word !== want.rom_word || m_source_kind !== want.source_kind ||
                    m_status !== want.status) begin
                    if (mismatch_count < 10)
                        $display("mismatch #%0d: word %h/%h kind %0d/%0d status %0d/%0d",
                                 results_checked, m_rom_word, want.rom_word,
                                 m_source_kind, want.source_kind, m_status, want.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        logic [31:0] bad_type;
        logic [31:0] limit_word;
        int          mark;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // bits above the 8-bit field must be dropped
        write_limit(32'hFFFF_FF02);

        // header: hunk count equal to the limit, first number at the top end
        add_row(MAGIC_HEADER, EXP_NONE, '0);
        add_row(32'h0000_0000, EXP_PREDICT, '0);
        add_row(32'hFFFF_FFFF, EXP_PREDICT, '0);
        add_row(32'hFFFF_FFFE, EXP_PREDICT, '0);
        add_row(32'hFFFF_FFFF, EXP_NONE, '0);
        add_row(32'h0000_0000, EXP_PREDICT, '0);
        add_row(32'hFFFF_FFFF, EXP_PREDICT, '0);
        add_row(TYPE_CODE, EXP_PREDICT, '0);
        add_row(32'd2, EXP_PREDICT, '0);
        add_row(32'h0000_0000, EXP_RESULT, '{32'h0000_0000, KIND_CODE, ST_OK});
        add_row(32'hFFFF_FFFF, EXP_RESULT, '{32'hFFFF_FFFF, KIND_CODE, ST_OK});
        add_row(TYPE_DATA, EXP_PREDICT, '0);
        add_row(32'd1, EXP_PREDICT, '0);
        add_row(32'hA5A5_5A5A, EXP_RESULT, '{32'hA5A5_5A5A, KIND_DATA, ST_OK});
        // zero-length code hunk, next word is a type again
        add_row(TYPE_CODE, EXP_PREDICT, '0);
        add_row(32'd0, EXP_PREDICT, '0);
        add_row(TYPE_SYMBOL, EXP_PREDICT, '0);
        add_row(32'd1, EXP_PREDICT, '0);
        add_row(TYPE_CODE, EXP_NONE, '0);
        add_row(32'hFFFF_FFFF, EXP_NONE, '0);
        add_row(32'd0, EXP_PREDICT, '0);
        add_row(TYPE_DEBUG, EXP_PREDICT, '0);
        add_row(32'd0, EXP_PREDICT, '0);
        add_row(TYPE_BSS, EXP_PREDICT, '0);
        add_row(32'hFFFF_FFFF, EXP_PREDICT, '0);
        add_row(TYPE_END, EXP_PREDICT, '0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_word(row.word, row.mode, row.res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1:       limit_word = 32'h0000_00FF;
                    2:       limit_word = 32'h0000_0001;
                    default: limit_word = {16'($urandom_range(16'hFFFF)), 16'h0000};
                endcase
                write_limit(limit_word);
            end
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            mark = words_sent;
            while (words_sent - mark < PHASE_WORDS - ((ph == 3) ? TAIL_WORDS : 0))
                emit_random_hunk();
        end

        // close the stream with an unknown hunk type; the error then sticks
        case ($urandom_range(4))
            0:       bad_type = 32'h0000_0000;
            1:       bad_type = 32'hFFFF_FFFF;
            2:       bad_type = MAGIC_HEADER;
            3:       bad_type = TYPE_BSS + 32'd1;
            default: bad_type = {1'b1, 31'($urandom)};
        endcase
        send_word(bad_type, EXP_RESULT, '{32'd0, KIND_CODE, ST_BAD_TYPE});
        repeat (TAIL_WORDS)
            send_word($urandom, EXP_RESULT, '{32'd0, KIND_CODE, ST_BAD_TYPE});

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d words: hunks code %0d, data %0d, symbol %0d, debug %0d,",
                 words_sent, n_code, n_data, n_sym, n_dbg);
        $display("bss %0d, end %0d", n_bss, n_end);
        $display("checked %0d results over four idle mixes and four limit writes, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && rom_expect.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[hunk_object_to_rom_extractor.f]
hdl/hoe_pkg.sv
hdl/hoe_step.sv
hdl/hoe_outbuf.sv
hdl/hunk_object_to_rom_extractor.sv
sim/testbench.sv
